// ===== rtl/label_bounding_box_center_top_defines.svh =====
// assertion macros for the label bounding box center block
`ifndef LABEL_BOUNDING_BOX_CENTER_TOP_DEFINES_SVH
`define LABEL_BOUNDING_BOX_CENTER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LBBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LBBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked during reset too
`define LBBC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lbbc_pkg.sv =====
package lbbc_pkg;

  localparam int MAX_LABELS = 64;
  localparam int MAX_DIM    = 1024;
  localparam int LABEL_W    = $clog2(MAX_LABELS);
  localparam int IN_LABEL_W = 8;
  localparam int COORD_W    = 10;
  localparam int FW_W       = 11;
  localparam int SEG_W      = 6;
  localparam int IDX_W      = 20;
  localparam int BOX_W      = 4 * COORD_W;
  localparam int MUL_W      = COORD_W + FW_W;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(1024);

  // input queue between front and back
  localparam int IQ_DEPTH = 4;
  localparam int IQ_PTR_W = $clog2(IQ_DEPTH);

  // result queue
  localparam int OQ_DEPTH = 2;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

  // register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH = REG_IDX_W'(0);

  typedef struct packed {
    logic                 pix_ok;
    logic [LABEL_W-1:0]   label;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic                 frame_end;
  } pix_t;

  typedef struct packed {
    logic   avail;
    pix_t   head;
  } iq_out_t;

  typedef struct packed {
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_y;
  } box_t;

  typedef struct packed {
    logic [SEG_W-1:0] seg_label;
    logic [IDX_W-1:0] center_index;
    logic             last;
  } res_t;

  typedef struct packed {
    logic push;
    res_t word;
  } res_push_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_SCAN,
    ST_CALC,
    ST_MUL,
    ST_EMIT
  } back_state_t;

endpackage

// ===== rtl/lbbc_ram.sv =====
module lbbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lbbc_front.sv =====
module lbbc_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [lbbc_pkg::IN_LABEL_W-1:0]    label,
  input  logic [lbbc_pkg::COORD_W-1:0]       pos_x,
  input  logic [lbbc_pkg::COORD_W-1:0]       pos_y,
  input  logic                               frame_end,
  output lbbc_pkg::iq_out_t                  q,
  input  logic                               q_pop
);

  lbbc_pkg::pix_t                 mem [lbbc_pkg::IQ_DEPTH];
  logic [lbbc_pkg::IQ_PTR_W-1:0]  wptr;
  logic [lbbc_pkg::IQ_PTR_W-1:0]  rptr;
  logic [lbbc_pkg::IQ_PTR_W:0]    count;
  logic                           pix_ok;
  logic                           wr;
  logic                           rd;
  lbbc_pkg::pix_t                 pix_in;

  // pixels outside the table only matter when they close the frame
  assign pix_ok = (32'(label) < 32'(lbbc_pkg::MAX_LABELS))
               && (32'(pos_x) < 32'(lbbc_pkg::MAX_DIM))
               && (32'(pos_y) < 32'(lbbc_pkg::MAX_DIM));

  assign pix_in = '{pix_ok:    pix_ok,
                    label:     lbbc_pkg::LABEL_W'(label),
                    x:         pos_x,
                    y:         pos_y,
                    frame_end: frame_end};

  assign full    = (count == (lbbc_pkg::IQ_PTR_W+1)'(lbbc_pkg::IQ_DEPTH));
  assign wr      = push && !full && (pix_ok || frame_end);
  assign rd      = q_pop && (count != '0);
  assign q.avail = (count != '0);
  assign q.head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= pix_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lbbc_back.sv =====
module lbbc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lbbc_pkg::FW_W-1:0]     frame_width,
  input  lbbc_pkg::iq_out_t             q,
  output logic                          q_pop,
  output lbbc_pkg::res_push_t           rp,
  input  logic                          out_full
);

  lbbc_pkg::back_state_t               state, state_next;
  lbbc_pkg::pix_t                      pix, pix_next;
  logic [lbbc_pkg::LABEL_W-1:0]        idx, idx_next;
  logic [lbbc_pkg::MAX_LABELS-1:0]     seen, seen_next;
  logic [lbbc_pkg::COORD_W-1:0]        cx, cx_next;
  logic [lbbc_pkg::COORD_W-1:0]        cy, cy_next;
  logic                                last_r, last_r_next;
  logic [lbbc_pkg::IDX_W-1:0]          prod, prod_next;

  logic                                we;
  logic [lbbc_pkg::LABEL_W-1:0]        raddr;
  logic [lbbc_pkg::BOX_W-1:0]          rdata;
  lbbc_pkg::box_t                      cur_box;
  lbbc_pkg::box_t                      new_box;
  logic [lbbc_pkg::MAX_LABELS-1:0]     seen_rest;
  logic [lbbc_pkg::MUL_W-1:0]          mul_full;

  lbbc_ram #(
    .WIDTH (lbbc_pkg::BOX_W),
    .DEPTH (lbbc_pkg::MAX_LABELS)
  ) u_box_ram (
    .clk   (clk),
    .we    (we),
    .waddr (pix.label),
    .wdata (new_box),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cur_box  = lbbc_pkg::box_t'(rdata);
  assign raddr    = (state == lbbc_pkg::ST_IDLE) ? q.head.label : idx;
  assign mul_full = lbbc_pkg::MUL_W'(cy) * lbbc_pkg::MUL_W'(frame_width);

  // first pixel of a label opens the box, later ones widen it
  always_comb begin
    if (!seen[pix.label]) begin
      new_box = '{min_x: pix.x, max_x: pix.x, min_y: pix.y, max_y: pix.y};
    end else begin
      new_box.min_x = (pix.x < cur_box.min_x) ? pix.x : cur_box.min_x;
      new_box.max_x = (pix.x > cur_box.max_x) ? pix.x : cur_box.max_x;
      new_box.min_y = (pix.y < cur_box.min_y) ? pix.y : cur_box.min_y;
      new_box.max_y = (pix.y > cur_box.max_y) ? pix.y : cur_box.max_y;
    end
  end

  always_comb begin
    seen_rest      = seen;
    seen_rest[idx] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbbc_pkg::ST_IDLE;
      seen  <= '0;
    end else begin
      state <= state_next;
      seen  <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    pix    <= pix_next;
    idx    <= idx_next;
    cx     <= cx_next;
    cy     <= cy_next;
    last_r <= last_r_next;
    prod   <= prod_next;
  end

  always_comb begin
    state_next  = state;
    pix_next    = pix;
    idx_next    = idx;
    seen_next   = seen;
    cx_next     = cx;
    cy_next     = cy;
    last_r_next = last_r;
    prod_next   = prod;
    q_pop       = 1'b0;
    we          = 1'b0;
    rp.push     = 1'b0;
    rp.word     = '{seg_label:    lbbc_pkg::SEG_W'(idx),
                    center_index: prod + lbbc_pkg::IDX_W'(cx),
                    last:         last_r};
    unique case (state)
      lbbc_pkg::ST_IDLE: begin
        if (q.avail) begin
          q_pop      = 1'b1;
          pix_next   = q.head;
          state_next = lbbc_pkg::ST_MERGE;
        end
      end
      lbbc_pkg::ST_MERGE: begin
        if (pix.pix_ok) begin
          we                   = 1'b1;
          seen_next[pix.label] = 1'b1;
        end
        if (pix.frame_end) begin
          idx_next   = '0;
          state_next = lbbc_pkg::ST_SCAN;
        end else begin
          state_next = lbbc_pkg::ST_IDLE;
        end
      end
      lbbc_pkg::ST_SCAN: begin
        if (seen[idx]) begin
          state_next = lbbc_pkg::ST_CALC;
        end else if (idx == lbbc_pkg::LABEL_W'(lbbc_pkg::MAX_LABELS - 1)) begin
          state_next = lbbc_pkg::ST_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      lbbc_pkg::ST_CALC: begin
        cx_next        = cur_box.min_x + ((cur_box.max_x - cur_box.min_x) >> 1);
        cy_next        = cur_box.min_y + ((cur_box.max_y - cur_box.min_y) >> 1);
        seen_next[idx] = 1'b0;
        last_r_next    = (seen_rest == '0);
        state_next     = lbbc_pkg::ST_MUL;
      end
      lbbc_pkg::ST_MUL: begin
        prod_next  = mul_full[lbbc_pkg::IDX_W-1:0];
        state_next = lbbc_pkg::ST_EMIT;
      end
      lbbc_pkg::ST_EMIT: begin
        if (!out_full) begin
          rp.push = 1'b1;
          if (last_r) begin
            state_next = lbbc_pkg::ST_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = lbbc_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_next = lbbc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/lbbc_out_buf.sv =====
module lbbc_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  lbbc_pkg::res_push_t    rp,
  output logic                   full,
  input  logic                   pop,
  output logic                   empty,
  output lbbc_pkg::res_t         head
);

  lbbc_pkg::res_t                 mem [lbbc_pkg::OQ_DEPTH];
  logic [lbbc_pkg::OQ_PTR_W-1:0]  wptr;
  logic [lbbc_pkg::OQ_PTR_W-1:0]  rptr;
  logic [lbbc_pkg::OQ_PTR_W:0]    count;
  logic                           wr;
  logic                           rd;

  assign full  = (count == (lbbc_pkg::OQ_PTR_W+1)'(lbbc_pkg::OQ_DEPTH));
  assign empty = (count == '0);
  assign wr    = rp.push && !full;
  assign rd    = pop && !empty;
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= rp.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/label_bounding_box_center_top.sv =====
// Bounding-box center finder for one frame of labelled pixels. Pixels (label, pos_x, pos_y,
// frame_end) enter through a queue port (push/full) into a 4-word input queue, so bursts are
// taken one word per cycle until the queue fills. The back part folds each pixel into a 64-entry
// box memory (min/max x and y per label) by a read and a write-back, and takes the next pixel
// only after that write-back; labels of 64 and above are dropped at the front unless they close
// the frame. The pixel marked frame_end is folded in first, then labels are scanned in ascending
// order up to the last present one: an absent label is skipped, a present one passes through
// memory read, center, multiply by frame_width and emit, which waits while the result side is
// full. Results come out in ascending label order on a queue port (empty/pop) through a 2-word
// result queue, with last set on the final center of the frame; a frame with no labels gives no
// result. The center index is center_y*frame_width+center_x, kept to 20 bits. frame_width sits
// at APB byte address 0 (reset 1024) and should be written only while the block is idle. No
// clearing pass is needed after reset: box entries are only read behind their seen bits.
module label_bounding_box_center_top (
  input  logic                               clk,
  input  logic                               rst,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lbbc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lbbc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lbbc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  // pixel words in
  input  logic                               push,
  output logic                               full,
  input  logic [lbbc_pkg::IN_LABEL_W-1:0]    label,
  input  logic [lbbc_pkg::COORD_W-1:0]       pos_x,
  input  logic [lbbc_pkg::COORD_W-1:0]       pos_y,
  input  logic                               frame_end,
  // center words out
  output logic                               empty,
  input  logic                               pop,
  output logic [lbbc_pkg::SEG_W-1:0]         seg_label,
  output logic [lbbc_pkg::IDX_W-1:0]         center_index,
  output logic                               last
);

  logic [lbbc_pkg::FW_W-1:0]       frame_width;
  logic [lbbc_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                            cfg_wr;
  lbbc_pkg::iq_out_t               iq;
  logic                            iq_pop;
  lbbc_pkg::res_push_t             rp;
  logic                            out_full;
  lbbc_pkg::res_t                  head;

  // register decode: one register per 32-bit word
  assign reg_idx = paddr[lbbc_pkg::APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    if (reg_idx == lbbc_pkg::REG_FRAME_WIDTH) begin
      prdata = lbbc_pkg::APB_DATA_W'(frame_width);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= lbbc_pkg::FW_RESET;
    end else if (cfg_wr && (reg_idx == lbbc_pkg::REG_FRAME_WIDTH)) begin
      frame_width <= pwdata[lbbc_pkg::FW_W-1:0];
    end
  end

  // front: accept, classify and queue pixel words
  lbbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .label     (label),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .frame_end (frame_end),
    .q         (iq),
    .q_pop     (iq_pop)
  );

  // back: box update and frame-end scan
  lbbc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_width (frame_width),
    .q           (iq),
    .q_pop       (iq_pop),
    .rp          (rp),
    .out_full    (out_full)
  );

  // result queue decouples the scan from the consumer
  lbbc_out_buf u_out_buf (
    .clk   (clk),
    .rst   (rst),
    .rp    (rp),
    .full  (out_full),
    .pop   (pop),
    .empty (empty),
    .head  (head)
  );

  assign seg_label    = head.seg_label;
  assign center_index = head.center_index;
  assign last         = head.last;

endmodule

// ===== rtl/lbbc_checker.sv =====
`include "label_bounding_box_center_top_defines.svh"

module lbbc_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pready,
  input  logic                               empty,
  input  logic                               pop,
  input  logic [lbbc_pkg::SEG_W-1:0]         seg_label,
  input  logic [lbbc_pkg::IDX_W-1:0]         center_index,
  input  logic                               last
);

  logic [lbbc_pkg::SEG_W+lbbc_pkg::IDX_W:0]  res_bits;
  logic                                      took_mid;

  assign res_bits = {seg_label, center_index, last};
  assign took_mid = pop && !empty && !last;

  // no center word is left over once reset is seen
  `LBBC_ASSERT_RST(a_empty_after_rst, rst, empty, "result queue not empty after reset")

  // a waiting word holds until taken
  `LBBC_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(res_bits), "waiting result changed")

  // within a frame the labels come out in ascending order
  `LBBC_ASSERT_NOW(a_label_order, took_mid ##1 !empty, seg_label > $past(seg_label), "label order")

  // the register port never waits
  `LBBC_ASSERT_NOW(a_pready, psel && penable, pready, "pready low on access")

endmodule

bind label_bounding_box_center_top lbbc_checker u_lbbc_checker (.*);

// ===== tb/tb_label_bounding_box_center_top.sv =====
`timescale 1ns / 1ps

// testbench for the label bounding box center block: pixel words go in through the push/full
// port, a local box table predicts the center words of each frame end, and every popped
// center word is compared field by field with the oldest predicted one
module tb_label_bounding_box_center_top;

  // cycles left for the block to finish its scan and drain queued pixels
  // after the last predicted center word has been popped
  localparam int SETTLE_CYCLES = 300;
  // hard stop for a hung run, far above the slowest legal run with full idling
  localparam int RUN_LIMIT_NS = 6_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // register port
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [lbbc_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [lbbc_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [lbbc_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  // pixel words in
  logic                            push = 1'b0;
  logic                            full;
  logic [lbbc_pkg::IN_LABEL_W-1:0] label = '0;
  logic [lbbc_pkg::COORD_W-1:0]    pos_x = '0;
  logic [lbbc_pkg::COORD_W-1:0]    pos_y = '0;
  logic                            frame_end = 1'b0;

  // center words out
  logic                            empty;
  logic                            pop = 1'b0;
  logic [lbbc_pkg::SEG_W-1:0]      seg_label;
  logic [lbbc_pkg::IDX_W-1:0]      center_index;
  logic                            last;

  label_bounding_box_center_top dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .push         (push),
    .full         (full),
    .label        (label),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .frame_end    (frame_end),
    .empty        (empty),
    .pop          (pop),
    .seg_label    (seg_label),
    .center_index (center_index),
    .last         (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // local copy of the box table and the width register
  logic [lbbc_pkg::FW_W-1:0]    width_now = lbbc_pkg::FW_RESET;
  logic                         label_present [lbbc_pkg::MAX_LABELS];
  logic [lbbc_pkg::COORD_W-1:0] box_lo_x [lbbc_pkg::MAX_LABELS];
  logic [lbbc_pkg::COORD_W-1:0] box_hi_x [lbbc_pkg::MAX_LABELS];
  logic [lbbc_pkg::COORD_W-1:0] box_lo_y [lbbc_pkg::MAX_LABELS];
  logic [lbbc_pkg::COORD_W-1:0] box_hi_y [lbbc_pkg::MAX_LABELS];

  // center words predicted but not yet popped, oldest first
  lbbc_pkg::res_t centers_due [$];

  int fails = 0;

  // idle rates in percent per word, 0 means a stretch with no idling
  int push_idle_pct = 0;
  int pop_idle_pct = 0;
  int pop_hold = 0;

  initial begin
    for (int i = 0; i < lbbc_pkg::MAX_LABELS; i++) label_present[i] = 1'b0;
  end

  // fold one accepted pixel into the table; a frame end then emits every
  // present label in ascending order and clears the table
  task automatic fold_pixel(input logic [lbbc_pkg::IN_LABEL_W-1:0] lab,
                            input logic [lbbc_pkg::COORD_W-1:0] x,
                            input logic [lbbc_pkg::COORD_W-1:0] y, input logic fe);
    int unsigned                  cx;
    int unsigned                  cy;
    int                           emitted;
    lbbc_pkg::res_t               word;
    logic [lbbc_pkg::LABEL_W-1:0] slot;
    emitted = 0;
    slot = lbbc_pkg::LABEL_W'(lab);
    // labels past the table are dropped, coordinates always fit the 10-bit range
    if (lab < lbbc_pkg::MAX_LABELS) begin
      if (!label_present[slot]) begin
        label_present[slot] = 1'b1;
        box_lo_x[slot] = x;
        box_hi_x[slot] = x;
        box_lo_y[slot] = y;
        box_hi_y[slot] = y;
      end else begin
        if (x < box_lo_x[slot]) box_lo_x[slot] = x;
        if (x > box_hi_x[slot]) box_hi_x[slot] = x;
        if (y < box_lo_y[slot]) box_lo_y[slot] = y;
        if (y > box_hi_y[slot]) box_hi_y[slot] = y;
      end
    end
    if (fe) begin
      for (int i = 0; i < lbbc_pkg::MAX_LABELS; i++) begin
        if (label_present[i]) begin
          // floored midpoint of the box, index wraps to 20 bits
          cx = box_lo_x[i] + (box_hi_x[i] - box_lo_x[i]) / 2;
          cy = box_lo_y[i] + (box_hi_y[i] - box_lo_y[i]) / 2;
          word.seg_label = lbbc_pkg::SEG_W'(i);
          word.center_index = lbbc_pkg::IDX_W'(cy * width_now + cx);
          word.last = 1'b0;
          centers_due = {centers_due, word};
          label_present[i] = 1'b0;
          emitted++;
        end
      end
      // empty frame gives nothing, else the final word carries last
      if (emitted > 0) centers_due[$].last = 1'b1;
    end
  endtask

  // compare one popped center word with the oldest prediction
  task automatic check_center();
    lbbc_pkg::res_t want;
    if (centers_due.size() == 0) begin
      $error("unexpected center word: seg_label %0d center_index %0d last %0d",
             seg_label, center_index, last);
      fails++;
    end else begin
      want = centers_due.pop_front();
      if (seg_label !== want.seg_label) begin
        $error("seg_label expected %0d actual %0d", want.seg_label, seg_label);
        fails++;
      end
      if (center_index !== want.center_index) begin
        $error("center_index expected %0d actual %0d", want.center_index, center_index);
        fails++;
      end
      if (last !== want.last) begin
        $error("last expected %0d actual %0d", want.last, last);
        fails++;
      end
    end
  endtask

  // result side: check each popped word, then pick pop for the next edge
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_center();
      if (pop_hold > 0) begin
        pop_hold = pop_hold - 1;
        pop <= 1'b0;
      end else if (pop_idle_pct > 0 && $urandom_range(99) < pop_idle_pct) begin
        // burst of stalled cycles of random length, this one included
        pop_hold = $urandom_range(1, 18) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // send one pixel word, with an optional random gap ahead of it, and predict at acceptance
  task automatic send_pixel(input logic [lbbc_pkg::IN_LABEL_W-1:0] lab,
                            input logic [lbbc_pkg::COORD_W-1:0] x,
                            input logic [lbbc_pkg::COORD_W-1:0] y, input logic fe);
    if (push_idle_pct > 0 && $urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    push <= 1'b1;
    label <= lab;
    pos_x <= x;
    pos_y <= y;
    frame_end <= fe;
    do @(posedge clk); while (full);
    fold_pixel(lab, x, y, fe);
  endtask

  // stop sending, wait for every predicted word, then let the block go quiet
  task automatic drain();
    push <= 1'b0;
    while (centers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write while the block is idle: setup cycle, then access cycle
  task automatic set_frame_width(input logic [lbbc_pkg::FW_W-1:0] w);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {lbbc_pkg::REG_FRAME_WIDTH, 2'b00};
    pwdata <= lbbc_pkg::APB_DATA_W'(w);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    width_now = w;
  endtask

  // one frame of random content: a few labels, noise pixels past the table,
  // sometimes a frame end on a dropped label
  task automatic run_frame(inout int sent);
    logic [lbbc_pkg::IN_LABEL_W-1:0] labs [8];
    logic [lbbc_pkg::IN_LABEL_W-1:0] lab;
    logic [lbbc_pkg::COORD_W-1:0]    x;
    logic [lbbc_pkg::COORD_W-1:0]    y;
    int                              n_lab;
    int                              n_pix;
    int                              spread;
    int                              span_x;
    int                              span_y;
    int                              base_x;
    int                              base_y;
    n_lab = $urandom_range(1, 8);
    for (int i = 0; i < n_lab; i++)
      labs[i] = lbbc_pkg::IN_LABEL_W'($urandom_range(0, lbbc_pkg::MAX_LABELS - 1));
    spread = $urandom_range(0, 3);
    span_x = $urandom_range(0, 63);
    span_y = $urandom_range(0, 63);
    base_x = $urandom_range(0, lbbc_pkg::MAX_DIM - 1 - span_x);
    base_y = $urandom_range(0, lbbc_pkg::MAX_DIM - 1 - span_y);
    n_pix = $urandom_range(1, 14);
    for (int p = 0; p < n_pix; p++) begin
      if ($urandom_range(9) == 0)
        lab = lbbc_pkg::IN_LABEL_W'($urandom_range(lbbc_pkg::MAX_LABELS, 255));
      else lab = labs[$urandom_range(0, n_lab - 1)];
      if (p == n_pix - 1 && $urandom_range(3) == 0)
        lab = lbbc_pkg::IN_LABEL_W'($urandom_range(lbbc_pkg::MAX_LABELS, 255));
      // whole image or a small region, so boxes are both wide and tight
      if (spread == 0) begin
        x = lbbc_pkg::COORD_W'($urandom_range(0, lbbc_pkg::MAX_DIM - 1));
        y = lbbc_pkg::COORD_W'($urandom_range(0, lbbc_pkg::MAX_DIM - 1));
      end else begin
        x = lbbc_pkg::COORD_W'(base_x + $urandom_range(0, span_x));
        y = lbbc_pkg::COORD_W'(base_y + $urandom_range(0, span_y));
      end
      send_pixel(lab, x, y, p == n_pix - 1);
      sent++;
    end
  endtask

  // field extremes, empty frame, dropped labels, box growth, width extremes
  task automatic test_directed_edges();
    push_idle_pct = 20;
    pop_idle_pct = 20;
    // reset width 1024
    send_pixel(8'd0, 10'd0, 10'd0, 1'b1);
    send_pixel(8'd63, 10'd1023, 10'd1023, 1'b1);
    // nothing present: frame end on a dropped label gives no word
    send_pixel(8'd255, 10'd1023, 10'd1023, 1'b1);
    // boxes grow in all four directions, odd span floors, dropped label closes the frame
    send_pixel(8'd5, 10'd7, 10'd3, 1'b0);
    send_pixel(8'd10, 10'd500, 10'd500, 1'b0);
    send_pixel(8'd10, 10'd100, 10'd900, 1'b0);
    send_pixel(8'd10, 10'd900, 10'd100, 1'b0);
    send_pixel(8'd2, 10'd0, 10'd0, 1'b0);
    send_pixel(8'd2, 10'd3, 10'd5, 1'b0);
    send_pixel(8'd64, 10'd1, 10'd1, 1'b1);
    // widest width wraps the index past 20 bits
    set_frame_width(11'd2047);
    send_pixel(8'd63, 10'd1023, 10'd1023, 1'b1);
    // zero width leaves only the column
    set_frame_width(11'd0);
    send_pixel(8'd20, 10'd7, 10'd900, 1'b1);
    set_frame_width(11'd1);
    send_pixel(8'd33, 10'd1023, 10'd1023, 1'b0);
    send_pixel(8'd33, 10'd0, 10'd0, 1'b1);
  endtask

  // every label present in one frame: the longest burst of center words
  task automatic test_full_table();
    logic [lbbc_pkg::IN_LABEL_W-1:0] order [lbbc_pkg::MAX_LABELS];
    logic [lbbc_pkg::IN_LABEL_W-1:0] tmp;
    int                              j;
    set_frame_width(lbbc_pkg::FW_W'($urandom_range(1, lbbc_pkg::MAX_DIM)));
    push_idle_pct = 10;
    pop_idle_pct = 30;
    for (int i = 0; i < lbbc_pkg::MAX_LABELS; i++) order[i] = lbbc_pkg::IN_LABEL_W'(i);
    for (int i = lbbc_pkg::MAX_LABELS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < lbbc_pkg::MAX_LABELS; i++)
      send_pixel(order[i], lbbc_pkg::COORD_W'($urandom_range(0, lbbc_pkg::MAX_DIM - 1)),
                 lbbc_pkg::COORD_W'($urandom_range(0, lbbc_pkg::MAX_DIM - 1)), 1'b0);
    send_pixel(lbbc_pkg::IN_LABEL_W'($urandom_range(lbbc_pkg::MAX_LABELS, 255)),
               lbbc_pkg::COORD_W'($urandom_range(0, lbbc_pkg::MAX_DIM - 1)),
               lbbc_pkg::COORD_W'($urandom_range(0, lbbc_pkg::MAX_DIM - 1)), 1'b1);
  endtask

  // random frames; calm keeps both sides streaming with no idling
  task automatic test_random_frames(input logic [lbbc_pkg::FW_W-1:0] w, input int n_items,
                                    input logic calm);
    int sent;
    sent = 0;
    set_frame_width(w);
    while (sent < n_items) begin
      if (calm) begin
        push_idle_pct = 0;
        pop_idle_pct = 0;
      end else if ($urandom_range(3) == 0) begin
        push_idle_pct = 0;
        pop_idle_pct = 0;
      end else begin
        push_idle_pct = $urandom_range(5, 40);
        pop_idle_pct = $urandom_range(5, 40);
      end
      run_frame(sent);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_full_table();
    test_random_frames(lbbc_pkg::FW_W'($urandom_range(1, lbbc_pkg::MAX_DIM)), 50, 1'b0);
    test_random_frames(lbbc_pkg::FW_RESET, 40, 1'b0);
    test_random_frames(lbbc_pkg::FW_W'($urandom_range(0, 2047)), 30, 1'b0);
    // last stretch runs back to back on both sides
    test_random_frames(lbbc_pkg::FW_W'($urandom_range(1, lbbc_pkg::MAX_DIM)), 30, 1'b1);
    drain();
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lbbc_pkg.sv
rtl/lbbc_ram.sv
rtl/lbbc_front.sv
rtl/lbbc_back.sv
rtl/lbbc_out_buf.sv
rtl/label_bounding_box_center_top.sv
rtl/lbbc_checker.sv
tb/tb_label_bounding_box_center_top.sv
